### sv/im2col_pkg.sv
// shared types and constants for the im2col column generator
// field widths, register map codes, opcodes and the pipeline item struct
// no dependencies
package im2col_pkg;

  // field widths
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 24;
  localparam int DIM_W       = 7;
  localparam int KER_W       = 5;
  localparam int STR_W       = 5;
  localparam int PAD_W       = 4;
  localparam int FILT_W      = 13;
  localparam int OP_W        = 2;
  localparam int TUSER_W     = 2;
  localparam int IN_TDATA_W  = DATA_W;
  localparam int OUT_TDATA_W = IDX_W + DATA_W;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  // walk counter and address path widths
  localparam int WIN_W   = 5;
  localparam int CH_W    = 7;
  localparam int POS_W   = 7;
  localparam int FC_W    = 12;
  localparam int SGN_W   = 9;
  localparam int COORD_W = 6;
  localparam int CHH_W   = 12;
  localparam int RAW_W   = 18;

  // limits
  localparam int MAX_DIM         = 64;
  localparam int MAX_KERNEL      = 16;
  localparam int MAX_STRIDE      = 16;
  localparam int MAX_FILTER      = 4096;
  localparam int ALIGN_WORDS     = 8;
  localparam int IMAGE_WORDS_DEF = 4096;

  // register reset values
  localparam logic [DIM_W-1:0]  RST_IN_WIDTH     = 7'd8;
  localparam logic [DIM_W-1:0]  RST_IN_HEIGHT    = 7'd8;
  localparam logic [DIM_W-1:0]  RST_IN_DEPTH     = 7'd1;
  localparam logic [KER_W-1:0]  RST_KERNEL_SIZE  = 5'd3;
  localparam logic [STR_W-1:0]  RST_STRIDE       = 5'd1;
  localparam logic [PAD_W-1:0]  RST_PAD_AMOUNT   = 4'd0;
  localparam logic [FILT_W-1:0] RST_FILTER_ELEMS = 13'd9;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_EMIT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_IN_WIDTH     = 3'd0,
    REG_IN_HEIGHT    = 3'd1,
    REG_IN_DEPTH     = 3'd2,
    REG_KERNEL_SIZE  = 3'd3,
    REG_STRIDE       = 3'd4,
    REG_PAD_AMOUNT   = 3'd5,
    REG_FILTER_ELEMS = 3'd6
  } reg_idx_t;

  // what travels down the address pipeline with each load or emit
  typedef struct packed {
    logic              is_load;
    logic [DATA_W-1:0] element;
    logic [IDX_W-1:0]  dest;
    logic              pad;
    logic              fin;
  } item_t;

endpackage

### sv/im2col_column_generator.sv
// im2col column generator top level: walk counters, address pipeline, image store
// depends on im2col_pkg
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+-------------------------------------------
//  s_*      | in        | s_tvalid / s_tready  | tuser: opcode; tdata: element (loads)
//  m_*      | out       | m_tvalid / m_tready  | tdata: dest_index, value; tuser: is_pad, finished
//  apb      | in        | psel/penable/pwrite  | seven geometry registers at 4*i, pready tied high
//
//  one item is taken per cycle unless the output stalls; a result leaves the output register
//  after its item has passed the input register, window coordinates, address product,
//  reduction quotient, store index, then the registered store read
//  the walk counters advance as the item leaves the input register, so items follow back to back
//  a stalled output holds its result and back-pressure travels up the stage valids to s_tready
//  rst is synchronous and clears the walk state and all valids; the image store is not cleared
module im2col_column_generator #(
  parameter int IMAGE_WORDS = im2col_pkg::IMAGE_WORDS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] element
  input  logic [im2col_pkg::TUSER_W-1:0]        s_tuser,   // [1:0] opcode
  // result items
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [im2col_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [23:0] dest_index, [55:24] value
  output logic [im2col_pkg::TUSER_W-1:0]        m_tuser,   // [0] is_pad, [1] finished
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [im2col_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [im2col_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [im2col_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int AW        = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
  localparam int LAST_ADDR = IMAGE_WORDS - 1;
  // reciprocal for the modulo reduction of the raw store address
  localparam int RECIP     = (1 << im2col_pkg::RAW_W) / IMAGE_WORDS;
  localparam int PROD_W    = 2 * im2col_pkg::RAW_W;

  localparam int DIM_W   = im2col_pkg::DIM_W;
  localparam int KER_W   = im2col_pkg::KER_W;
  localparam int STR_W   = im2col_pkg::STR_W;
  localparam int FILT_W  = im2col_pkg::FILT_W;
  localparam int IDX_W   = im2col_pkg::IDX_W;
  localparam int DATA_W  = im2col_pkg::DATA_W;
  localparam int WIN_W   = im2col_pkg::WIN_W;
  localparam int CH_W    = im2col_pkg::CH_W;
  localparam int POS_W   = im2col_pkg::POS_W;
  localparam int FC_W    = im2col_pkg::FC_W;
  localparam int SGN_W   = im2col_pkg::SGN_W;
  localparam int COORD_W = im2col_pkg::COORD_W;
  localparam int CHH_W   = im2col_pkg::CHH_W;
  localparam int RAW_W   = im2col_pkg::RAW_W;

  // saturating add for the destination index
  function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] a,
                                              input logic [IDX_W:0]   b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + b;
    return sum[IDX_W] ? {IDX_W{1'b1}} : sum[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------------------------
  logic [DIM_W-1:0]                in_width;
  logic [DIM_W-1:0]                in_height;
  logic [DIM_W-1:0]                in_depth;
  logic [KER_W-1:0]                kernel_size;
  logic [STR_W-1:0]                stride;
  logic [im2col_pkg::PAD_W-1:0]    pad_amount;
  logic [FILT_W-1:0]               filter_elems;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width     <= im2col_pkg::RST_IN_WIDTH;
      in_height    <= im2col_pkg::RST_IN_HEIGHT;
      in_depth     <= im2col_pkg::RST_IN_DEPTH;
      kernel_size  <= im2col_pkg::RST_KERNEL_SIZE;
      stride       <= im2col_pkg::RST_STRIDE;
      pad_amount   <= im2col_pkg::RST_PAD_AMOUNT;
      filter_elems <= im2col_pkg::RST_FILTER_ELEMS;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        im2col_pkg::REG_IN_WIDTH:     in_width     <= pwdata[DIM_W-1:0];
        im2col_pkg::REG_IN_HEIGHT:    in_height    <= pwdata[DIM_W-1:0];
        im2col_pkg::REG_IN_DEPTH:     in_depth     <= pwdata[DIM_W-1:0];
        im2col_pkg::REG_KERNEL_SIZE:  kernel_size  <= pwdata[KER_W-1:0];
        im2col_pkg::REG_STRIDE:       stride       <= pwdata[STR_W-1:0];
        im2col_pkg::REG_PAD_AMOUNT:   pad_amount   <= pwdata[im2col_pkg::PAD_W-1:0];
        im2col_pkg::REG_FILTER_ELEMS: filter_elems <= pwdata[FILT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      im2col_pkg::REG_IN_WIDTH:     prdata = 32'(in_width);
      im2col_pkg::REG_IN_HEIGHT:    prdata = 32'(in_height);
      im2col_pkg::REG_IN_DEPTH:     prdata = 32'(in_depth);
      im2col_pkg::REG_KERNEL_SIZE:  prdata = 32'(kernel_size);
      im2col_pkg::REG_STRIDE:       prdata = 32'(stride);
      im2col_pkg::REG_PAD_AMOUNT:   prdata = 32'(pad_amount);
      im2col_pkg::REG_FILTER_ELEMS: prdata = 32'(filter_elems);
      default:                      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // clamped geometry, as used by the walk
  logic [DIM_W-1:0]  w_c, h_c, d_c;
  logic [KER_W-1:0]  k_c;
  logic [STR_W-1:0]  s_c;
  logic [FILT_W-1:0] f_c;

  always_comb begin
    w_c = (in_width == '0) ? DIM_W'(1) :
          (in_width > DIM_W'(im2col_pkg::MAX_DIM)) ? DIM_W'(im2col_pkg::MAX_DIM) : in_width;
    h_c = (in_height == '0) ? DIM_W'(1) :
          (in_height > DIM_W'(im2col_pkg::MAX_DIM)) ? DIM_W'(im2col_pkg::MAX_DIM) : in_height;
    d_c = (in_depth == '0) ? DIM_W'(1) :
          (in_depth > DIM_W'(im2col_pkg::MAX_DIM)) ? DIM_W'(im2col_pkg::MAX_DIM) : in_depth;
    k_c = (kernel_size == '0) ? KER_W'(1) :
          (kernel_size > KER_W'(im2col_pkg::MAX_KERNEL)) ? KER_W'(im2col_pkg::MAX_KERNEL) :
          kernel_size;
    s_c = (stride == '0) ? STR_W'(1) :
          (stride > STR_W'(im2col_pkg::MAX_STRIDE)) ? STR_W'(im2col_pkg::MAX_STRIDE) : stride;
    f_c = (filter_elems == '0) ? FILT_W'(1) :
          (filter_elems > FILT_W'(im2col_pkg::MAX_FILTER)) ? FILT_W'(im2col_pkg::MAX_FILTER) :
          filter_elems;
  end

  // ---------------------------------------------------------------------------------------------
  // pipeline handshake: each stage moves on when the one after it is empty or moving
  // ---------------------------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5, rdy_o;

  assign rdy_o    = !m_tvalid || m_tready;
  assign rdy5     = !v5 || rdy_o;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;

  // input register
  logic [im2col_pkg::OP_W-1:0] op1;
  logic [DATA_W-1:0]           elem1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      op1   <= s_tuser;
      elem1 <= s_tdata;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // walk state
  // ---------------------------------------------------------------------------------------------
  logic [AW-1:0]    load_address;
  logic [POS_W-1:0] pos_row, pos_col;
  logic [CH_W-1:0]  channel;
  logic [WIN_W-1:0] win_row, win_col;
  logic [FC_W-1:0]  filter_count;
  logic [IDX_W-1:0] next_index;
  logic             done_flag;

  // carried counters and the window coordinate for the item in the input register
  logic signed [SGN_W-1:0] lim_r, lim_c, hm1, wm1, rmax, cmax, rr, cc, h_s, w_s;
  logic [WIN_W-1:0]        wc_a, wr_a;
  logic [CH_W-1:0]         ch_a;
  logic [POS_W-1:0]        pc_a, pr_a;
  logic                    done_a, pad_a;
  logic [CHH_W-1:0]        chh_a;
  logic [FC_W:0]           fc_inc;
  logic [FC_W-1:0]         fc_new;
  logic [IDX_W-1:0]        idx_inc, idx_new;
  logic [AW-1:0]           la_inc;

  always_comb begin
    // largest valid output coordinate per axis, negative when no window fits
    lim_r = SGN_W'(h_c) + SGN_W'({pad_amount, 1'b0}) - SGN_W'(k_c);
    lim_c = SGN_W'(w_c) + SGN_W'({pad_amount, 1'b0}) - SGN_W'(k_c);
    hm1   = SGN_W'(h_c) - SGN_W'(1);
    wm1   = SGN_W'(w_c) - SGN_W'(1);
    rmax  = (lim_r < hm1) ? lim_r : hm1;
    cmax  = (lim_c < wm1) ? lim_c : wm1;
    h_s   = SGN_W'(h_c);
    w_s   = SGN_W'(w_c);

    // roll each counter past its bound into the next level
    wc_a   = win_col;
    wr_a   = win_row;
    ch_a   = channel;
    pc_a   = pos_col;
    pr_a   = pos_row;
    done_a = done_flag;
    if (!done_flag) begin
      if (wc_a >= k_c) begin
        wc_a = '0;
        wr_a = wr_a + WIN_W'(1);
      end
      if (wr_a >= k_c) begin
        wr_a = '0;
        ch_a = ch_a + CH_W'(1);
      end
      if (ch_a >= d_c) begin
        ch_a = '0;
        pc_a = pc_a + POS_W'(s_c);
      end
      if (cmax[SGN_W-1] || $signed(SGN_W'(pc_a)) > cmax) begin
        pc_a = '0;
        pr_a = pr_a + POS_W'(s_c);
      end
      if (rmax[SGN_W-1] || cmax[SGN_W-1] || $signed(SGN_W'(pr_a)) > rmax) begin
        done_a = 1'b1;
      end
    end

    // image coordinate of this window element, shifted by the border
    rr    = SGN_W'(pr_a) - SGN_W'(pad_amount) + SGN_W'(wr_a);
    cc    = SGN_W'(pc_a) - SGN_W'(pad_amount) + SGN_W'(wc_a);
    pad_a = rr[SGN_W-1] || cc[SGN_W-1] || (rr >= h_s) || (cc >= w_s);

    // channel offset in rows, first half of the address product
    chh_a = CHH_W'(ch_a) * CHH_W'(h_c);

    // destination index with the jump to the next aligned filter slot
    idx_inc = sat_add(next_index, (IDX_W+1)'(1));
    fc_inc  = {1'b0, filter_count} + (FC_W+1)'(1);
    if (fc_inc >= (FC_W+1)'(f_c)) begin
      idx_new = sat_add(idx_inc, (IDX_W+1)'(im2col_pkg::ALIGN_WORDS)
                                 - (IDX_W+1)'(f_c % im2col_pkg::ALIGN_WORDS));
      fc_new  = '0;
    end else begin
      idx_new = idx_inc;
      fc_new  = fc_inc[FC_W-1:0];
    end

    la_inc = (load_address == AW'(LAST_ADDR)) ? '0 : load_address + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= '0;
      pos_row      <= '0;
      pos_col      <= '0;
      channel      <= '0;
      win_row      <= '0;
      win_col      <= '0;
      filter_count <= '0;
      next_index   <= '0;
      done_flag    <= 1'b0;
    end else if (v1 && rdy2) begin
      unique case (op1)
        im2col_pkg::OP_LOAD: begin
          load_address <= la_inc;
        end
        im2col_pkg::OP_EMIT: begin
          pos_row   <= pr_a;
          pos_col   <= pc_a;
          channel   <= ch_a;
          win_row   <= wr_a;
          done_flag <= done_a;
          if (done_a) begin
            win_col <= wc_a;
          end else begin
            win_col      <= wc_a + WIN_W'(1);
            filter_count <= fc_new;
            next_index   <= idx_new;
          end
        end
        im2col_pkg::OP_RESTART: begin
          // the image store keeps its contents
          load_address <= '0;
          pos_row      <= '0;
          pos_col      <= '0;
          channel      <= '0;
          win_row      <= '0;
          win_col      <= '0;
          filter_count <= '0;
          next_index   <= '0;
          done_flag    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stage 2: window coordinate and channel offset
  // ---------------------------------------------------------------------------------------------
  im2col_pkg::item_t it2, it3, it4, it5;
  logic [COORD_W-1:0] r2, c2;
  logic [CHH_W-1:0]   chh2;
  logic [AW-1:0]      la2, la3, la4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      // restarts and unused codes end here
      v2 <= v1 && (op1 == im2col_pkg::OP_LOAD || op1 == im2col_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      it2.is_load <= (op1 == im2col_pkg::OP_LOAD);
      it2.element <= elem1;
      it2.dest    <= done_a ? '0 : next_index;
      it2.pad     <= !done_a && pad_a;
      it2.fin     <= done_a;
      r2          <= rr[COORD_W-1:0];
      c2          <= cc[COORD_W-1:0];
      chh2        <= chh_a;
      la2         <= load_address;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stage 3: raw store address, column + width * (row + channel * height)
  // ---------------------------------------------------------------------------------------------
  logic [RAW_W-1:0] raw_a, raw3, raw4;

  assign raw_a = (RAW_W'(r2) + RAW_W'(chh2)) * RAW_W'(w_c) + RAW_W'(c2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      it3  <= it2;
      raw3 <= raw_a;
      la3  <= la2;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stage 4: quotient estimate by the store size, never more than one too small
  // ---------------------------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_q;
  logic [RAW_W-1:0]  q4;

  assign prod_q = PROD_W'(raw3) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      it4  <= it3;
      raw4 <= raw3;
      q4   <= prod_q[PROD_W-1:RAW_W];
      la4  <= la3;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stage 5: remainder with one correction step gives the wrapped store index
  // ---------------------------------------------------------------------------------------------
  logic [RAW_W-1:0] qn, rem, rem_fix;
  logic [AW-1:0]    idx_a, idx5;

  always_comb begin
    qn      = q4 * RAW_W'(IMAGE_WORDS);
    rem     = raw4 - qn;
    rem_fix = (rem >= RAW_W'(IMAGE_WORDS)) ? rem - RAW_W'(IMAGE_WORDS) : rem;
    idx_a   = it4.is_load ? la4 : rem_fix[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      it5  <= it4;
      idx5 <= idx_a;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // image store and output register; loads write here, in order with the reads
  // ---------------------------------------------------------------------------------------------
  logic [DATA_W-1:0] image_store [IMAGE_WORDS];
  logic [DATA_W-1:0] rdata;
  logic [IDX_W-1:0]  out_dest;
  logic              out_pad, out_fin;

  always_ff @(posedge clk) begin
    if (v5 && rdy_o && it5.is_load) begin
      image_store[idx5] <= it5.element;
    end
    if (rdy_o) begin
      rdata <= image_store[idx5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_o) begin
      m_tvalid <= v5 && !it5.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_dest <= it5.dest;
      out_pad  <= it5.pad;
      out_fin  <= it5.fin;
    end
  end

  // padded and finished items carry a zero word
  assign m_tdata = {(out_pad || out_fin) ? '0 : rdata, out_dest};
  assign m_tuser = {out_fin, out_pad};

endmodule

### sv/im2col_checker.sv
// port-level checks for the im2col column generator, bound to the top level
// depends on im2col_pkg and im2col_column_generator
module im2col_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [im2col_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [im2col_pkg::TUSER_W-1:0]     m_tuser
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // a finished result carries nothing else
  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("finished result with non-zero fields");

  // a padded element carries a zero word
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[im2col_pkg::OUT_TDATA_W-1:im2col_pkg::IDX_W] == '0)
    else $error("padded result with non-zero value");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind im2col_column_generator im2col_checker u_im2col_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
